/* sv/rfys_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types of the ranged Fisher-Yates shuffler.
package rfys_pkg;

   // Element store geometry
   localparam int DEPTH      = 1024;
   localparam int ELEM_WIDTH = 32;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Transaction field widths
   localparam int CMD_W       = 2;
   localparam int FIELD_IDX_W = 10;
   localparam int DATA_W      = 32;
   localparam int SEED_W      = 64;

   // Bounds compare width: holds any field index and DEPTH itself
   localparam int CMP_W  = ((ADDR_W > FIELD_IDX_W) ? ADDR_W : FIELD_IDX_W) + 1;
   // Shuffle span (i - start + 1) and remainder width
   localparam int SPAN_W = FIELD_IDX_W + 1;

   // Generator and divider
   localparam int GEN_W   = 64;
   localparam int ROT_A   = 55;
   localparam int SHIFT_B = 14;
   localparam int ROT_C   = 36;
   localparam int CNT_W   = $clog2(GEN_W);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SHUFFLE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESEED  = 2'd3;

   // Status codes
   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef logic [ELEM_WIDTH-1:0] elem_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DRAW,
      ST_DIVIDE,
      ST_LOAD_I,
      ST_LOAD_J,
      ST_STORE_I,
      ST_STORE_J,
      ST_REPLY
   } seq_state_type;

endpackage

/* sv/ranged_fisher_yates_shuffler_core.sv */
`timescale 1ns / 1ps
// Ranged Fisher-Yates shuffler: element store, xoroshiro128+ generator, sequencer.
//
// One command is taken when start is high and busy is low; busy stays high until the
// result has been shown. Every command gives one result on rsp_* for one cycle, marked
// by rsp_valid, and the receiver cannot stall it. A write or a read passes through
// ST_WRITE or ST_READ first; a reseed, a one-entry shuffle or a rejected command shows
// its result in the cycle after acceptance. A shuffle of start..end makes end - start
// swaps: each draws one generator word, reduces it modulo the span in a restoring
// divider that retires one dividend bit per cycle, then steps through LOAD_I, LOAD_J,
// STORE_I and STORE_J to swap the entries. The store is not cleared after reset;
// reading an entry never written returns whatever it holds.
module ranged_fisher_yates_shuffler_core (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                start,
   output logic                                busy,
   input  logic [rfys_pkg::CMD_W-1:0]          req_command,
   input  logic [rfys_pkg::FIELD_IDX_W-1:0]    req_index,
   input  logic [rfys_pkg::DATA_W-1:0]         req_write_data,
   input  logic [rfys_pkg::FIELD_IDX_W-1:0]    req_range_start,
   input  logic [rfys_pkg::FIELD_IDX_W-1:0]    req_range_end,
   // result channel
   output logic                                rsp_valid,
   output logic [rfys_pkg::DATA_W-1:0]         rsp_read_data,
   output logic                                rsp_status,
   // seed register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rfys_pkg::SEED_W-1:0]         csr_data
);
   import rfys_pkg::*;

   // Sequencer
   seq_state_type state_ff, state_in;

   // Latched transaction
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [FIELD_IDX_W-1:0] index_ff, index_in;
   logic [DATA_W-1:0]      wdata_ff, wdata_in;
   logic [FIELD_IDX_W-1:0] rs_ff, rs_in;
   logic [FIELD_IDX_W-1:0] i_ff, i_in;
   logic                   status_ff, status_in;

   // Seed and generator
   logic [SEED_W-1:0] seed_ff;
   logic [GEN_W-1:0]  gen_lo_ff, gen_lo_in;
   logic [GEN_W-1:0]  gen_hi_ff, gen_hi_in;

   // Divider
   logic [GEN_W-1:0]  dvd_ff, dvd_in;
   logic [SPAN_W-1:0] rem_ff, rem_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Element store
   elem_type          store_mem [DEPTH];
   elem_type          rdata_ff;
   elem_type          tmp_ff, tmp_in;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   elem_type          mem_wd;
   logic [ADDR_W-1:0] mem_ra;

   // Decode helpers
   logic                   accept;
   logic                   index_ok;
   logic                   range_ok;
   logic                   single;
   logic                   div_last;
   logic [FIELD_IDX_W-1:0] j_idx;
   logic [GEN_W-1:0]       gen_sum;
   logic [GEN_W-1:0]       gen_x;
   logic [SPAN_W:0]        div_trial;
   logic [SPAN_W:0]        span_ext;

   assign accept   = start && !busy;
   assign index_ok = (CMP_W'(req_index) < CMP_W'(DEPTH));
   assign range_ok = (req_range_start <= req_range_end) &&
                     (CMP_W'(req_range_end) < CMP_W'(DEPTH));
   assign single   = (req_range_start == req_range_end);
   assign div_last = (cnt_ff == CNT_W'(GEN_W - 1));
   assign j_idx    = rs_ff + FIELD_IDX_W'(rem_ff);

   // xoroshiro128+ output and mixing term
   assign gen_sum = gen_lo_ff + gen_hi_ff;
   assign gen_x   = gen_lo_ff ^ gen_hi_ff;

   // Restoring divider trial: shift in the next dividend bit
   assign div_trial = {rem_ff, dvd_ff[GEN_W-1]};
   assign span_ext  = {1'b0, span_ff};

   // Seed register: always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_W'(1);
      end else if (csr_valid && csr_ready) begin
         seed_ff <= csr_data;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_WRITE:   state_in = index_ok ? ST_WRITE : ST_REPLY;
                  CMD_READ:    state_in = index_ok ? ST_READ : ST_REPLY;
                  CMD_SHUFFLE: state_in = (range_ok && !single) ? ST_DRAW : ST_REPLY;
                  default:     state_in = ST_REPLY;
               endcase
            end
         end
         ST_WRITE:   state_in = ST_REPLY;
         ST_READ:    state_in = ST_REPLY;
         ST_DRAW:    state_in = ST_DIVIDE;
         ST_DIVIDE:  state_in = div_last ? ST_LOAD_I : ST_DIVIDE;
         ST_LOAD_I:  state_in = ST_LOAD_J;
         ST_LOAD_J:  state_in = ST_STORE_I;
         ST_STORE_I: state_in = ST_STORE_J;
         ST_STORE_J: state_in = ((i_ff - FIELD_IDX_W'(1)) == rs_ff) ? ST_REPLY : ST_DRAW;
         ST_REPLY:   state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake, result strobe and store port controls
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      rsp_valid     = 1'b0;
      rsp_read_data = '0;
      rsp_status    = STATUS_DONE;
      mem_we        = 1'b0;
      mem_wa        = ADDR_W'(i_ff);
      mem_wd        = rdata_ff;
      mem_ra        = ADDR_W'(i_ff);
      case (state_ff)
         ST_WRITE: begin
            mem_we = 1'b1;
            mem_wa = ADDR_W'(index_ff);
            mem_wd = ELEM_WIDTH'(wdata_ff);
         end
         ST_READ: begin
            mem_ra = ADDR_W'(index_ff);
         end
         ST_LOAD_J: begin
            mem_ra = ADDR_W'(j_idx);
         end
         ST_STORE_I: begin
            // entry i takes the value read from j
            mem_we = 1'b1;
            mem_wa = ADDR_W'(i_ff);
            mem_wd = rdata_ff;
         end
         ST_STORE_J: begin
            // entry j takes the saved value of i
            mem_we = 1'b1;
            mem_wa = ADDR_W'(j_idx);
            mem_wd = tmp_ff;
         end
         ST_REPLY: begin
            rsp_valid  = 1'b1;
            rsp_status = status_ff;
            if (cmd_ff == CMD_READ && status_ff == STATUS_DONE) begin
               rsp_read_data = DATA_W'(rdata_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      cmd_in    = cmd_ff;
      index_in  = index_ff;
      wdata_in  = wdata_ff;
      rs_in     = rs_ff;
      i_in      = i_ff;
      status_in = status_ff;
      gen_lo_in = gen_lo_ff;
      gen_hi_in = gen_hi_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      span_in   = span_ff;
      cnt_in    = cnt_ff;
      tmp_in    = tmp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // latch the transaction, decide its status and, on a reseed, load the generator
               cmd_in   = req_command;
               index_in = req_index;
               wdata_in = req_write_data;
               rs_in    = req_range_start;
               i_in     = req_range_end;
               case (req_command)
                  CMD_WRITE:   status_in = index_ok ? STATUS_DONE : STATUS_REJECT;
                  CMD_READ:    status_in = index_ok ? STATUS_DONE : STATUS_REJECT;
                  CMD_SHUFFLE: status_in = range_ok ? STATUS_DONE : STATUS_REJECT;
                  default: begin
                     status_in = STATUS_DONE;
                     gen_lo_in = seed_ff | GEN_W'(1);
                     gen_hi_in = {seed_ff[SEED_W-33:0], 32'd0} | GEN_W'(1);
                  end
               endcase
            end
         end
         ST_DRAW: begin
            // advance the generator and load its output as the dividend
            dvd_in    = gen_sum;
            gen_lo_in = {gen_lo_ff[GEN_W-1-ROT_A:0], gen_lo_ff[GEN_W-1:GEN_W-ROT_A]} ^
                        gen_x ^ (gen_x << SHIFT_B);
            gen_hi_in = {gen_x[GEN_W-1-ROT_C:0], gen_x[GEN_W-1:GEN_W-ROT_C]};
            rem_in    = '0;
            cnt_in    = '0;
            span_in   = SPAN_W'({1'b0, i_ff} - {1'b0, rs_ff} + SPAN_W'(1));
         end
         ST_DIVIDE: begin
            // one restoring step per cycle
            if (div_trial >= span_ext) begin
               rem_in = SPAN_W'(div_trial - span_ext);
            end else begin
               rem_in = SPAN_W'(div_trial);
            end
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_LOAD_J: begin
            // hold entry i while j is fetched
            tmp_in = rdata_ff;
         end
         ST_STORE_J: begin
            i_in = i_ff - FIELD_IDX_W'(1);
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         gen_lo_ff <= GEN_W'(1);
         gen_hi_ff <= GEN_W'(1);
         cnt_ff    <= '0;
         status_ff <= STATUS_DONE;
         cmd_ff    <= CMD_WRITE;
      end else begin
         state_ff  <= state_in;
         gen_lo_ff <= gen_lo_in;
         gen_hi_ff <= gen_hi_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
         cmd_ff    <= cmd_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      index_ff <= index_in;
      wdata_ff <= wdata_in;
      rs_ff    <= rs_in;
      i_ff     <= i_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      span_ff  <= span_in;
      tmp_ff   <= tmp_in;
   end

   // Element store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= store_mem[mem_ra];
   end

   // Checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_no_result_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_valid)
      else $error("command accepted while a result is shown");

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < span_ff))
      else $error("divider remainder reached the span");

   a_j_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD_J) |-> (j_idx <= i_ff && j_idx >= rs_ff))
      else $error("swap partner outside the shuffle range");

   a_reject_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_REJECT) |-> (rsp_read_data == '0))
      else $error("rejected transaction carries read data");

endmodule
